>>> rtl/utf8_slug_generator_defines.svh
// Assertion macros for the slug generator RTL.
// Included by usg_queue, the module that carries concurrent checks; no other dependency.
`ifndef UTF8_SLUG_GENERATOR_DEFINES_SVH
`define UTF8_SLUG_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define USG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define USG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define USG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define USG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/usg_pkg.sv
// Types, constants and byte classification functions of the slug generator.
// Used by usg_front, usg_queue, usg_back and the top level.
package usg_pkg;

    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;
    localparam logic [7:0] CASE_OFS  = 8'd32;

    localparam logic [7:0] MASK_2B = 8'hE0;
    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] MASK_3B = 8'hF0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] MASK_4B = 8'hF8;
    localparam logic [7:0] LEAD_4B = 8'hF0;

    localparam int MAX_RES = 5;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } fr_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       fin;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [2:0]              count;
        logic                    sup;
        logic                    pen;
    } emit_t;

    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] len;
        if ((c & MASK_2B) == LEAD_2B) len = 3'd2;
        else if ((c & MASK_3B) == LEAD_3B) len = 3'd3;
        else if ((c & MASK_4B) == LEAD_4B) len = 3'd4;
        else len = 3'd1;
        return len;
    endfunction

    function automatic emit_t emit_push(input emit_t e, input logic [7:0] b);
        emit_t r;
        r = e;
        r.bytes[r.count] = b;
        r.count = r.count + 3'd1;
        return r;
    endfunction

    function automatic emit_t emit_release(input emit_t e);
        emit_t r;
        r = e;
        if (r.pen)
        begin
            r = emit_push(r, CH_HYPHEN);
            r.pen = 1'b0;
        end
        r.sup = 1'b0;
        return r;
    endfunction

    function automatic emit_t emit_ascii(input emit_t e, input logic [7:0] c);
        emit_t r;
        logic  upper;
        logic  lower;
        logic  digit;
        r = e;
        upper = (c >= CH_UP_A) && (c <= CH_UP_Z);
        lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
        digit = (c >= CH_DIG_0) && (c <= CH_DIG_9);
        if (upper || lower || digit)
        begin
            r = emit_release(r);
            r = emit_push(r, upper ? c + CASE_OFS : c);
        end
        else if (!r.sup)
        begin
            r.pen = 1'b1;
            r.sup = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> rtl/utf8_slug_generator.sv
// Top level of the UTF-8 slug generator: front end, result queue, back end.
// Depends on usg_pkg, usg_front, usg_queue and usg_back.
//
// channel   dir   tdata           tuser       tlast
// s_*       in    in_byte [7:0]   -           in_last
// m_*       out   out_byte [7:0]  out_valid   out_end
//
// An input byte that yields no result is taken with the front end idle;
// one that yields n results (up to five) holds off s_* while the front
// end pushes them into the queue, one per cycle while the queue has room.
// Results pass through the output register of usg_back on their way to m_*.
// Reset is asynchronous; afterwards the block is ready at once.
// A stall on m_* fills the queue and then holds off s_*.
module utf8_slug_generator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] out_valid
    output logic       m_tlast
);

    usg_pkg::q_stat_t q_stat;
    usg_pkg::res_t    push_item;
    usg_pkg::res_t    head_item;
    logic             push;
    logic             pop;

    usg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    usg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    usg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_item (head_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/usg_front.sv
// Front end: accepts input bytes, tracks hyphen and multi-byte sequence state
// and pushes the resulting slug bytes into the queue. Depends on usg_pkg.
module usg_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    input  usg_pkg::q_stat_t q_stat,
    output logic             push,
    output usg_pkg::res_t    push_item
);

    usg_pkg::fr_state_t state_reg, state_next;

    logic                                  sup_reg;
    logic                                  pen_reg;
    logic [3:0][7:0]                       buf_reg, buf_next;
    logic [2:0]                            need_reg, need_next;
    logic [2:0]                            have_reg, have_next;

    logic [usg_pkg::MAX_RES-1:0][7:0]      list_reg;
    logic [2:0]                            cnt_reg;
    logic [2:0]                            idx_reg;
    logic                                  end_reg;
    logic                                  bare_reg;

    usg_pkg::emit_t                        e;
    logic [2:0]                            len;
    logic                                  tail_two;
    logic                                  accept;
    logic                                  has_work;
    logic                                  bare;
    logic                                  drain_done;

    assign accept     = s_tvalid && s_tready;
    assign bare       = s_tlast && (e.count == 3'd0);
    assign has_work   = (e.count != 3'd0) || s_tlast;
    assign drain_done = push && (idx_reg == cnt_reg - 3'd1);

    always_comb
    begin
        e         = '{bytes: '0, count: 3'd0, sup: sup_reg, pen: pen_reg};
        buf_next  = buf_reg;
        need_next = need_reg;
        have_next = have_reg;
        len       = 3'd1;
        tail_two  = 1'b0;
        if (need_reg == 3'd0)
        begin
            if (!s_tdata[7])
            begin
                e = usg_pkg::emit_ascii(e, s_tdata);
            end
            else
            begin
                len = usg_pkg::lead_len(s_tdata);
                if (len == 3'd1)
                begin
                    e = usg_pkg::emit_release(e);
                    e = usg_pkg::emit_push(e, s_tdata);
                end
                else
                begin
                    buf_next[0] = s_tdata;
                    have_next   = 3'd1;
                    need_next   = len;
                end
            end
        end
        else
        begin
            buf_next[have_reg[1:0]] = s_tdata;
            have_next = have_reg + 3'd1;
            if (have_next >= need_reg)
            begin
                e = usg_pkg::emit_release(e);
                for (int k = 0; k < 4; k++)
                begin
                    if (3'(k) < need_reg)
                    begin
                        e = usg_pkg::emit_push(e, buf_next[k]);
                    end
                end
                need_next = 3'd0;
                have_next = 3'd0;
            end
        end
        if (s_tlast)
        begin
            if (need_next != 3'd0)
            begin
                if (have_next >= 3'd2)
                begin
                    if (!buf_next[1][7])
                    begin
                        e        = usg_pkg::emit_ascii(e, buf_next[1]);
                        tail_two = 1'b1;
                    end
                    else
                    begin
                        len = usg_pkg::lead_len(buf_next[1]);
                        if (len == 3'd1)
                        begin
                            e        = usg_pkg::emit_release(e);
                            e        = usg_pkg::emit_push(e, buf_next[1]);
                            tail_two = 1'b1;
                        end
                        else if ((len == 3'd2) && (have_next == 3'd3))
                        begin
                            e = usg_pkg::emit_release(e);
                            e = usg_pkg::emit_push(e, buf_next[1]);
                            e = usg_pkg::emit_push(e, buf_next[2]);
                        end
                        else
                        begin
                            tail_two = 1'b1;
                        end
                    end
                end
                if (tail_two && (have_next == 3'd3))
                begin
                    if (!buf_next[2][7])
                    begin
                        e = usg_pkg::emit_ascii(e, buf_next[2]);
                    end
                    else if (usg_pkg::lead_len(buf_next[2]) == 3'd1)
                    begin
                        e = usg_pkg::emit_release(e);
                        e = usg_pkg::emit_push(e, buf_next[2]);
                    end
                end
            end
            need_next = 3'd0;
            have_next = 3'd0;
            e.pen     = 1'b0;
            e.sup     = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            usg_pkg::ST_IDLE:
            begin
                if (s_tvalid && has_work)
                begin
                    state_next = usg_pkg::ST_DRAIN;
                end
            end
            usg_pkg::ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = usg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = usg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        push      = 1'b0;
        push_item = '{data: bare_reg ? 8'd0 : list_reg[idx_reg], valid: !bare_reg,
                      fin: end_reg && (idx_reg == cnt_reg - 3'd1)};
        case (state_reg)
            usg_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            usg_pkg::ST_DRAIN:
            begin
                push = !q_stat.full;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= usg_pkg::ST_IDLE;
            sup_reg   <= 1'b1;
            pen_reg   <= 1'b0;
            need_reg  <= 3'd0;
            have_reg  <= 3'd0;
            idx_reg   <= 3'd0;
            cnt_reg   <= 3'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                sup_reg  <= e.sup;
                pen_reg  <= e.pen;
                need_reg <= need_next;
                have_reg <= have_next;
                idx_reg  <= 3'd0;
                cnt_reg  <= bare ? 3'd1 : e.count;
            end
            else if (push)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg  <= buf_next;
            list_reg <= e.bytes;
            end_reg  <= s_tlast;
            bare_reg <= bare;
        end
    end

endmodule

>>> rtl/usg_queue.sv
// Result queue between front and back end of the slug generator.
// Depends on usg_pkg and the assertion macros header.
`include "utf8_slug_generator_defines.svh"

module usg_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  usg_pkg::res_t    push_item,
    input  logic             pop,
    output usg_pkg::res_t    head_item,
    output usg_pkg::q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    usg_pkg::res_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `USG_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !stat.full, "push into full queue")
    `USG_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !stat.empty, "pop from empty queue")
    `USG_ASSERT_NXT(a_cnt_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not rise")
    `USG_ASSERT_NXT(a_cnt_dn, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 1'b1, "queue count did not fall")

endmodule

>>> rtl/usg_back.sv
// Back end: moves queued results into the output register of the master side.
// Depends on usg_pkg.
module usg_back (
    input  logic             clk,
    input  logic             rst_n,
    input  usg_pkg::q_stat_t q_stat,
    input  usg_pkg::res_t    head_item,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    logic          valid_reg;
    usg_pkg::res_t out_reg;

    assign pop      = !q_stat.empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.valid;
    assign m_tlast  = out_reg.fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= head_item;
        end
    end

endmodule

>>> tb/utf8_slug_generator_check.sv
`timescale 1ns / 100ps
// Checker for the slug generator: watches both stream channels, predicts each slug result
// from the accepted input bytes and compares it with what leaves the block.
// Depends on usg_pkg for the result type and character constants.
module utf8_slug_generator_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tuser,
    input  logic       m_tlast,
    output int         mismatches,
    output int         pending
);

    logic          dash_blocked;
    logic          dash_held;
    logic [7:0]    seq_bytes [4];
    logic [2:0]    seq_want;
    logic [2:0]    seq_got;
    usg_pkg::res_t step_out [$];
    usg_pkg::res_t slug_expect [$];

    function automatic int utf8_width(input logic [7:0] c);
        int w;
        casez (c)
            8'b110?????: w = 2;
            8'b1110????: w = 3;
            8'b11110???: w = 4;
            default:     w = 1;
        endcase
        return w;
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        usg_pkg::res_t r;
        r.data  = b;
        r.valid = 1'b1;
        r.fin   = 1'b0;
        step_out.push_back(r);
    endtask

    task automatic flush_dash();
        if (dash_held)
            emit_byte(usg_pkg::CH_HYPHEN);
        dash_held    = 1'b0;
        dash_blocked = 1'b0;
    endtask

    task automatic text_byte(input logic [7:0] c);
        logic is_upper;
        logic is_alnum;
        is_upper = (c >= usg_pkg::CH_UP_A) && (c <= usg_pkg::CH_UP_Z);
        is_alnum = is_upper
                   || ((c >= usg_pkg::CH_LO_A) && (c <= usg_pkg::CH_LO_Z))
                   || ((c >= usg_pkg::CH_DIG_0) && (c <= usg_pkg::CH_DIG_9));
        if (is_alnum)
        begin
            flush_dash();
            emit_byte(is_upper ? c + usg_pkg::CASE_OFS : c);
        end
        else if (!dash_blocked)
        begin
            dash_held    = 1'b1;
            dash_blocked = 1'b1;
        end
    endtask

    // rerun the bytes after a dropped lead byte as if the string ended with them
    task automatic replay_tail();
        int stop;
        int i;
        int w;
        stop = (seq_got > 3'd4) ? 4 : int'(seq_got);
        i = 1;
        while (i < stop)
        begin
            if (seq_bytes[i] < 8'd128)
            begin
                text_byte(seq_bytes[i]);
                i++;
            end
            else
            begin
                w = utf8_width(seq_bytes[i]);
                if (i + w <= stop)
                begin
                    flush_dash();
                    for (int k = 0; k < w; k++)
                        emit_byte(seq_bytes[i + k]);
                    i += w;
                end
                else
                    i++;
            end
        end
    endtask

    task automatic predict_transfer(input logic [7:0] b, input logic last);
        usg_pkg::res_t r;
        step_out.delete();
        if (seq_want == 3'd0)
        begin
            if (b < 8'd128)
                text_byte(b);
            else if (utf8_width(b) == 1)
            begin
                flush_dash();
                emit_byte(b);
            end
            else
            begin
                seq_bytes[0] = b;
                seq_got      = 3'd1;
                seq_want     = 3'(utf8_width(b));
            end
        end
        else
        begin
            seq_bytes[seq_got[1:0]] = b;
            seq_got = seq_got + 3'd1;
            if (seq_got >= seq_want)
            begin
                flush_dash();
                for (int k = 0; k < int'(seq_want) && k < 4; k++)
                    emit_byte(seq_bytes[k]);
                seq_want = 3'd0;
                seq_got  = 3'd0;
            end
        end
        if (last)
        begin
            if (seq_want != 3'd0)
                replay_tail();
            seq_want     = 3'd0;
            seq_got      = 3'd0;
            dash_held    = 1'b0;
            dash_blocked = 1'b1;
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].fin = 1'b1;
            else
            begin
                r.data  = 8'h00;
                r.valid = 1'b0;
                r.fin   = 1'b1;
                step_out.push_back(r);
            end
        end
        foreach (step_out[i])
            slug_expect.push_back(step_out[i]);
    endtask

    task automatic check_result();
        usg_pkg::res_t want;
        if (slug_expect.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected transfer: expected none, got byte %02h valid %0b end %0b",
                     $time, m_tdata, m_tuser, m_tlast);
        end
        else
        begin
            want = slug_expect.pop_front();
            if (want.data !== m_tdata || want.valid !== m_tuser || want.fin !== m_tlast)
            begin
                mismatches++;
                $display("%0t: expected byte %02h valid %0b end %0b, %s %02h valid %0b end %0b",
                         $time, want.data, want.valid, want.fin, "got byte",
                         m_tdata, m_tuser, m_tlast);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_blocked = 1'b1;
            dash_held    = 1'b0;
            seq_want     = 3'd0;
            seq_got      = 3'd0;
            mismatches   = 0;
            slug_expect.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_transfer(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
        end
        pending = slug_expect.size();
    end

endmodule

>>> tb/utf8_slug_generator_test.sv
`timescale 1ns / 100ps
// Top of the slug generator testbench: clock, reset, heading strings and the verdict.
// Depends on utf8_slug_generator and utf8_slug_generator_check.
module utf8_slug_generator_test;

    localparam int TEXT_BYTES  = 325;
    localparam int CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;
    int         mismatches;
    int         pending;
    int         bytes_sent;
    int         cycle_count;
    logic       calm;
    logic       hold_off;
    logic [7:0] heading [$];

    // {last, byte}
    logic [8:0] opening_text [0:23] = '{
        9'h000, 9'h041, 9'h02D, 9'h07F, 9'h15A,
        9'h080, 9'h0F8, 9'h1FF,
        9'h061, 9'h020, 9'h0F0, 9'h09F, 9'h098, 9'h180,
        9'h0C3, 9'h141,
        9'h030, 9'h0E2, 9'h141,
        9'h0F0, 9'h0C3, 9'h1A9,
        9'h120,
        9'h1E0
    };

    utf8_slug_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    utf8_slug_generator_check checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        calm = (bytes_sent >= 100) && (bytes_sent < 170);
        if (bytes_sent == 240)
            hold_off = 1'b1;
        if (!calm && $urandom_range(0, 99) < 27)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] cont_byte();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
            c = 8'($urandom);
        else
            c = {2'b10, 6'($urandom)};
        return c;
    endfunction

    // fill the heading with tokens, sometimes ending on a cut sequence
    task automatic build_heading();
        int         tokens;
        int         pick;
        int         w;
        logic [7:0] c;
        heading.delete();
        tokens = $urandom_range(1, 16);
        for (int t = 0; t < tokens; t++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                case ($urandom_range(0, 2))
                    0:       c = 8'($urandom_range(usg_pkg::CH_UP_A, usg_pkg::CH_UP_Z));
                    1:       c = 8'($urandom_range(usg_pkg::CH_LO_A, usg_pkg::CH_LO_Z));
                    default: c = 8'($urandom_range(usg_pkg::CH_DIG_0, usg_pkg::CH_DIG_9));
                endcase
                heading.push_back(c);
            end
            else if (pick < 65)
                heading.push_back(8'($urandom_range(0, 127)));
            else if (pick < 85)
            begin
                w = $urandom_range(2, 4);
                case (w)
                    2:       heading.push_back({3'b110, 5'($urandom)});
                    3:       heading.push_back({4'b1110, 4'($urandom)});
                    default: heading.push_back({5'b11110, 3'($urandom)});
                endcase
                for (int k = 1; k < w; k++)
                    heading.push_back(cont_byte());
            end
            else if (pick < 90)
                heading.push_back($urandom_range(0, 1) ? {2'b10, 6'($urandom)}
                                                       : {5'b11111, 3'($urandom)});
            else
                heading.push_back(8'($urandom));
        end
        if ($urandom_range(0, 99) < 30)
        begin
            w = $urandom_range(2, 4);
            case (w)
                2:       heading.push_back({3'b110, 5'($urandom)});
                3:       heading.push_back({4'b1110, 4'($urandom)});
                default: heading.push_back({5'b11110, 3'($urandom)});
            endcase
            for (int k = $urandom_range(0, w - 2); k > 0; k--)
                heading.push_back(8'($urandom));
        end
    endtask

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 27);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("utf8_slug_generator_test NOT OK");
        $finish;
    end

    initial
    begin
        calm       = 1'b0;
        hold_off   = 1'b0;
        bytes_sent = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (opening_text[i])
            send_byte(opening_text[i][7:0], opening_text[i][8]);
        while (bytes_sent < TEXT_BYTES)
        begin
            build_heading();
            foreach (heading[i])
                send_byte(heading[i], i == heading.size() - 1);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("utf8_slug_generator_test OK");
        else
            $display("utf8_slug_generator_test NOT OK");
        $finish;
    end

endmodule
